>>> rtl/core/psa_pkg.sv
// shared types and constants for the pool slot allocator
// no dependencies; every other source file uses this package

package psa_pkg;

	localparam int POOL_SLOTS = 1024;
	localparam int SLOT_W     = $clog2(POOL_SLOTS);
	localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} psa_cmd_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EMPTY      = 2'd1,
		ST_NOT_ACTIVE = 2'd2
	} psa_status_t;

	// read request into the slot store, issued when a word is accepted
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] stk_addr;
		logic [SLOT_W-1:0] flg_addr;
	} psa_rd_t;

	// writes from the request that commits this cycle
	typedef struct packed {
		logic              stk_we;
		logic [SLOT_W-1:0] stk_addr;
		logic [SLOT_W-1:0] stk_data;
		logic              flg_we;
		logic [SLOT_W-1:0] flg_addr;
		logic              flg_data;
	} psa_wr_t;

endpackage

>>> rtl/core/psa_if.sv
// request and result channels of the pool slot allocator
// depends on psa_pkg

interface psa_req_if;
	logic                      valid;
	logic                      ready;
	psa_pkg::psa_cmd_t         command;
	logic [psa_pkg::SLOT_W-1:0] slot;

	modport source (output valid, output command, output slot, input ready);
	modport sink   (input valid, input command, input slot, output ready);
endinterface

interface psa_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [psa_pkg::SLOT_W-1:0] granted_slot;
	psa_pkg::psa_status_t      status;
	logic [psa_pkg::CNT_W-1:0] active_count;

	modport source (output valid, output granted_slot, output status, output active_count,
		input ready);
	modport sink   (input valid, input granted_slot, input status, input active_count,
		output ready);
endinterface

>>> rtl/core/pool_slot_allocator_top.sv
// pool slot allocator: one request per cycle unless the result side stalls; the
// result is registered behind the request register.
// sustained rate one word per cycle when not stalled, set by the single request stage.
// idle list kept as a stack; entries below the low-water mark read as reset order.
// asynchronous reset clears control and pointers; memories need no clearing pass.
// depends on psa_pkg, psa_if, psa_store

module pool_slot_allocator_top (
	input  logic      clk,
	input  logic      arst_n,
	psa_req_if.sink   req,
	psa_rsp_if.source rsp
);
	import psa_pkg::*;

	logic              valid_s1;
	psa_cmd_t          cmd_s1;
	logic [SLOT_W-1:0] slot_s1;

	logic [CNT_W-1:0]  sp_q;
	logic [CNT_W-1:0]  lw_q;

	logic              rsp_valid_q;
	logic [SLOT_W-1:0] granted_q;
	psa_status_t       status_q;
	logic [CNT_W-1:0]  count_q;

	logic              advance;
	logic              accept;

	psa_rd_t           rd;
	psa_wr_t           wr;
	logic [SLOT_W-1:0] stk_data;
	logic              flg_data;

	logic [CNT_W-1:0]  pos;
	logic              from_init;
	logic [SLOT_W-1:0] pop_slot;
	logic [CNT_W:0]    popped_sum;
	logic              is_active;
	logic [CNT_W-1:0]  sp_nxt;
	logic [CNT_W-1:0]  lw_nxt;
	logic [CNT_W-1:0]  sp_eff;
	logic [SLOT_W-1:0] granted_nxt;
	psa_status_t       status_nxt;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	psa_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd       (rd),
		.wr       (wr),
		.stk_data (stk_data),
		.flg_data (flg_data)
	);

	// stack top and the slot value a never-written entry holds
	assign pos       = sp_q - CNT_W'(1);
	assign from_init = pos < lw_q;
	assign pop_slot  = from_init ? SLOT_W'(CNT_W'(POOL_SLOTS - 1) - pos) : stk_data;

	// a slot has left the idle stack iff the mark fell to or below its reset position
	assign popped_sum = (CNT_W + 1)'(slot_s1) + (CNT_W + 1)'(lw_q);
	assign is_active  = (CNT_W'(slot_s1) < CNT_W'(POOL_SLOTS))
		&& (popped_sum < (CNT_W + 1)'(POOL_SLOTS)) && flg_data;

	always_comb begin
		sp_nxt      = sp_q;
		lw_nxt      = lw_q;
		granted_nxt = '0;
		status_nxt  = ST_OK;
		wr          = '0;
		case (cmd_s1)
			CMD_ALLOC: begin
				if (sp_q == '0) begin
					status_nxt = ST_EMPTY;
				end else begin
					granted_nxt = pop_slot;
					sp_nxt      = pos;
					if (from_init) begin
						lw_nxt = pos;
					end
					wr.flg_we   = advance;
					wr.flg_addr = pop_slot;
					wr.flg_data = 1'b1;
				end
			end
			CMD_FREE: begin
				if (!is_active) begin
					status_nxt = ST_NOT_ACTIVE;
				end else begin
					granted_nxt = slot_s1;
					sp_nxt      = sp_q + CNT_W'(1);
					wr.stk_we   = advance;
					wr.stk_addr = sp_q[SLOT_W-1:0];
					wr.stk_data = slot_s1;
					wr.flg_we   = advance;
					wr.flg_addr = slot_s1;
					wr.flg_data = 1'b0;
				end
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	// the next word reads against the stack pointer left by the committing one
	assign sp_eff      = advance ? sp_nxt : sp_q;
	assign rd.en       = accept;
	assign rd.stk_addr = SLOT_W'(sp_eff - CNT_W'(1));
	assign rd.flg_addr = req.slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			sp_q        <= CNT_W'(POOL_SLOTS);
			lw_q        <= CNT_W'(POOL_SLOTS);
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
				sp_q        <= sp_nxt;
				lw_q        <= lw_nxt;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= req.command;
			slot_s1 <= req.slot;
		end
		if (advance) begin
			granted_q <= granted_nxt;
			status_q  <= status_nxt;
			count_q   <= CNT_W'(POOL_SLOTS) - sp_nxt;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.granted_slot = granted_q;
	assign rsp.status       = status_q;
	assign rsp.active_count = count_q;

endmodule

>>> rtl/core/psa_store.sv
// slot store: idle stack memory and active flag memory, registered reads
// with bypass of the write that lands on the same edge; depends on psa_pkg

module psa_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  psa_pkg::psa_rd_t            rd,
	input  psa_pkg::psa_wr_t            wr,
	output logic [psa_pkg::SLOT_W-1:0]  stk_data,
	output logic                        flg_data
);
	import psa_pkg::*;

	logic [SLOT_W-1:0] stk_mem [POOL_SLOTS];
	logic              flg_mem [POOL_SLOTS];

	logic [SLOT_W-1:0] stk_rd_q;
	logic              flg_rd_q;
	logic              stk_byp_q;
	logic              flg_byp_q;
	logic [SLOT_W-1:0] stk_byp_data_q;
	logic              flg_byp_data_q;

	always_ff @(posedge clk) begin
		if (wr.stk_we) begin
			stk_mem[wr.stk_addr] <= wr.stk_data;
		end
		if (wr.flg_we) begin
			flg_mem[wr.flg_addr] <= wr.flg_data;
		end
		if (rd.en) begin
			stk_rd_q       <= stk_mem[rd.stk_addr];
			flg_rd_q       <= flg_mem[rd.flg_addr];
			stk_byp_data_q <= wr.stk_data;
			flg_byp_data_q <= wr.flg_data;
		end
	end

	// memory read returns old data when the committing request writes the same entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stk_byp_q <= 1'b0;
			flg_byp_q <= 1'b0;
		end else if (rd.en) begin
			stk_byp_q <= wr.stk_we && (wr.stk_addr == rd.stk_addr);
			flg_byp_q <= wr.flg_we && (wr.flg_addr == rd.flg_addr);
		end
	end

	assign stk_data = stk_byp_q ? stk_byp_data_q : stk_rd_q;
	assign flg_data = flg_byp_q ? flg_byp_data_q : flg_rd_q;

endmodule

>>> dv/tb_top.sv
// self-checking testbench for the pool slot allocator: directed, pool exhaustion,
// back-pressure and random request streams against a linked-list predictor
// depends on psa_pkg, psa_if (psa_req_if, psa_rsp_if) and pool_slot_allocator_top

module tb_top;
	import psa_pkg::*;

	localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(POOL_SLOTS);
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS = 200;
	localparam int DRAIN_WORDS = 256;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		psa_status_t       status;
		logic [CNT_W-1:0]  count;
	} result_word_t;

	logic clk;
	logic arst_n;

	psa_req_if req_ch();
	psa_rsp_if rsp_ch();

	pool_slot_allocator_top DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// predictor state: both lists share the link arrays
	logic [CNT_W-1:0] link_fwd[POOL_SLOTS];
	logic [CNT_W-1:0] link_back[POOL_SLOTS];
	bit               slot_busy[POOL_SLOTS];
	logic [CNT_W-1:0] idle_top;
	logic [CNT_W-1:0] busy_top;
	logic [CNT_W-1:0] busy_total;

	result_word_t      pending_results[$];
	logic [SLOT_W-1:0] live_slots[$];

	int fail_count;
	int cycle_count;
	int stall_left;
	int sink_wait;
	bit no_idle;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	function automatic int draw_wait();
		if (no_idle)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	function automatic void reset_lists();
		for (int i = 0; i < POOL_SLOTS; i++) begin
			link_back[i] = (i == 0) ? NULL_LINK : CNT_W'(i - 1);
			link_fwd[i]  = (i == POOL_SLOTS - 1) ? NULL_LINK : CNT_W'(i + 1);
			slot_busy[i] = 1'b0;
		end
		busy_top   = NULL_LINK;
		idle_top   = '0;
		busy_total = '0;
	endfunction

	function automatic void detach(input logic [CNT_W-1:0] s, inout logic [CNT_W-1:0] head);
		logic [CNT_W-1:0] lo;
		logic [CNT_W-1:0] hi;
		lo = link_back[s[SLOT_W-1:0]];
		hi = link_fwd[s[SLOT_W-1:0]];
		link_back[s[SLOT_W-1:0]] = NULL_LINK;
		link_fwd[s[SLOT_W-1:0]]  = NULL_LINK;
		if (lo != NULL_LINK)
			link_fwd[lo[SLOT_W-1:0]] = hi;
		if (hi != NULL_LINK)
			link_back[hi[SLOT_W-1:0]] = lo;
		if (head == s)
			head = hi;
	endfunction

	function automatic void attach(input logic [CNT_W-1:0] s, inout logic [CNT_W-1:0] head);
		link_back[s[SLOT_W-1:0]] = NULL_LINK;
		link_fwd[s[SLOT_W-1:0]]  = head;
		if (head != NULL_LINK)
			link_back[head[SLOT_W-1:0]] = s;
		head = s;
	endfunction

	// every 10-bit index lies inside the pool, so only the busy flag decides a free
	function automatic result_word_t pool_apply(psa_cmd_t cmd, logic [SLOT_W-1:0] s);
		result_word_t r;
		logic [CNT_W-1:0] pick;
		r.slot   = '0;
		r.status = ST_OK;
		if (cmd == CMD_ALLOC) begin
			pick = idle_top;
			if (pick == NULL_LINK) begin
				r.status = ST_EMPTY;
			end else begin
				detach(pick, idle_top);
				attach(pick, busy_top);
				slot_busy[pick[SLOT_W-1:0]] = 1'b1;
				busy_total++;
				r.slot = pick[SLOT_W-1:0];
			end
		end else begin
			if (!slot_busy[s]) begin
				r.status = ST_NOT_ACTIVE;
			end else begin
				detach(CNT_W'(s), busy_top);
				attach(CNT_W'(s), idle_top);
				slot_busy[s] = 1'b0;
				busy_total--;
				r.slot = s;
			end
		end
		r.count = busy_total;
		return r;
	endfunction

	function automatic void flag_error(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR @%0t: %s", $time, msg);
	endfunction

	task automatic send_word(input psa_cmd_t cmd, input logic [SLOT_W-1:0] s);
		int gap;
		result_word_t r;
		gap = draw_wait();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.command <= cmd;
		req_ch.slot    <= s;
		do
			@(posedge clk);
		while (!req_ch.ready);
		r = pool_apply(cmd, s);
		pending_results.insert(pending_results.size(), r);
		// keep the stimulus view of allocated slots in step with the predictor
		if (r.status == ST_OK) begin
			if (cmd == CMD_ALLOC) begin
				live_slots.insert(live_slots.size(), r.slot);
			end else begin
				for (int i = 0; i < live_slots.size(); i++) begin
					if (live_slots[i] == s) begin
						live_slots.delete(i);
						break;
					end
				end
			end
		end
	endtask

	task automatic free_random_live();
		int idx;
		idx = $urandom_range(0, live_slots.size() - 1);
		send_word(CMD_FREE, live_slots[idx]);
	endtask

	task automatic check_result();
		result_word_t want;
		if (pending_results.size() == 0) begin
			flag_error($sformatf("unexpected word slot=%0d status=%0d count=%0d",
				rsp_ch.granted_slot, rsp_ch.status, rsp_ch.active_count));
		end else begin
			want = pending_results.pop_front();
			if (rsp_ch.granted_slot !== want.slot || rsp_ch.status !== want.status ||
				rsp_ch.active_count !== want.count)
				flag_error($sformatf(
					"exp slot=%0d status=%0d count=%0d, got slot=%0d status=%0d count=%0d",
					want.slot, want.status, want.count,
					rsp_ch.granted_slot, rsp_ch.status, rsp_ch.active_count));
		end
	endtask

	// result side: random ready gaps plus an optional long hold-off
	initial begin
		rsp_ch.ready <= 1'b0;
		sink_wait = 0;
		wait (arst_n === 1'b1);
		forever begin
			rsp_ch.ready <= (sink_wait == 0 && stall_left == 0);
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				check_result();
				sink_wait = draw_wait();
			end else if (sink_wait > 0) begin
				sink_wait--;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (stall_left > 0)
				stall_left--;
		end
	end

	task automatic test_directed();
		send_word(CMD_FREE, 10'd0);
		send_word(CMD_FREE, 10'd1023);
		send_word(CMD_ALLOC, 10'd1023);
		send_word(CMD_ALLOC, 10'd0);
		send_word(CMD_ALLOC, 10'h2aa);
		send_word(CMD_FREE, 10'd1);
		send_word(CMD_FREE, 10'd1);
		send_word(CMD_ALLOC, 10'h155);
		// active list is now 1, 2, 0: free from the middle, the tail, then the head
		send_word(CMD_FREE, 10'd2);
		send_word(CMD_FREE, 10'd0);
		send_word(CMD_FREE, 10'd1);
		send_word(CMD_ALLOC, 10'd0);
		send_word(CMD_ALLOC, 10'd1023);
		send_word(CMD_FREE, 10'd1023);
	endtask

	task automatic test_backpressure();
		no_idle = 1'b1;
		stall_left = 300;
		for (int i = 0; i < 40; i++) begin
			if (i % 3 == 2 && live_slots.size() > 0)
				free_random_live();
			else
				send_word(CMD_ALLOC, 10'($urandom));
		end
		no_idle = 1'b0;
	endtask

	task automatic test_exhaustion();
		while (busy_total != NULL_LINK)
			send_word(CMD_ALLOC, 10'($urandom));
		repeat (3) send_word(CMD_ALLOC, 10'($urandom));
		send_word(CMD_FREE, live_slots[$urandom_range(0, live_slots.size() - 1)]);
		send_word(CMD_ALLOC, 10'd0);
		send_word(CMD_ALLOC, 10'd1023);
		// free a random part of the pool so the idle list ends up scrambled
		repeat (DRAIN_WORDS) begin
			if (live_slots.size() > 0)
				free_random_live();
		end
		send_word(CMD_FREE, 10'($urandom));
	endtask

	task automatic test_random();
		int alloc_pct;
		int roll;
		for (int chunk = 0; chunk < RANDOM_WORDS / 100; chunk++) begin
			no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 2))
				0: alloc_pct = 25;
				1: alloc_pct = 50;
				default: alloc_pct = 75;
			endcase
			for (int i = 0; i < 100; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 85) begin
					if (live_slots.size() == 0 || $urandom_range(0, 99) < alloc_pct)
						send_word(CMD_ALLOC, 10'($urandom));
					else
						free_random_live();
				end else if (roll < 95) begin
					send_word(CMD_FREE, 10'($urandom));
				end else begin
					send_word(CMD_ALLOC, 10'($urandom));
				end
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		fail_count = 0;
		stall_left = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.command <= CMD_ALLOC;
		req_ch.slot    <= '0;
		reset_lists();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_exhaustion();
		test_random();

		req_ch.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/psa_pkg.sv
rtl/core/psa_if.sv
rtl/core/psa_store.sv
rtl/core/pool_slot_allocator_top.sv
dv/tb_top.sv
